@@ rtl/mts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Midtones transfer stretch package
// Widths, register indexes and the transaction types that pass between the
// divider cells of the stretch pipeline.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VW        = FRAC_BITS + 1;      // sample and register width
    localparam int DW        = 2 * FRAC_BITS + 4;  // divider datapath width
    localparam int NSTEP     = FRAC_BITS + 1;      // quotient bits, one per cell

    typedef logic [VW-1:0] t_val;

    localparam t_val ONE_V  = VW'(1) << FRAC_BITS;
    localparam t_val HALF_V = VW'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        REG_SHADOW    = 2'd0,
        REG_HIGHLIGHT = 2'd1,
        REG_MIDTONE   = 2'd2,
        REG_MODE      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic inv;
        logic force_en;
        t_val fval;
        t_val pix;
    } t_tag;

    typedef struct packed {
        t_tag          tag;
        logic [DW-1:0] r;
        logic [DW-1:0] b;
        t_val          q;
    } t_div;

    // Rounds the quotient with its guard bit, or gives the forced value.
    function automatic t_val div_round(input t_div d);
        logic [VW:0] qq;
        qq = {1'b0, d.q} + (VW+1)'(1);
        return d.tag.force_en ? d.tag.fval : qq[VW:1];
    endfunction

endpackage
`default_nettype wire

@@ rtl/mts_div_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit and hands the partial remainder on.
// ----------------------------------------------------------------------------
module mts_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mts_pkg::t_div i_d,
    output mts_pkg::t_div      o_d
);

    logic [mts_pkg::DW:0] r2;
    logic [mts_pkg::DW:0] diff;
    logic                 ge;
    mts_pkg::t_div        n_d;
    mts_pkg::t_div        r_d;

    always_comb begin
        r2   = {i_d.r, 1'b0};
        diff = r2 - {1'b0, i_d.b};
        ge   = (r2 >= {1'b0, i_d.b});
        n_d  = i_d;
        n_d.r = ge ? diff[mts_pkg::DW-1:0] : r2[mts_pkg::DW-1:0];
        n_d.q = {i_d.q[mts_pkg::VW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
        if (!i_rst_n) begin
            r_d.tag.valid <= 1'b0;
        end
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

@@ rtl/mts_div_chain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Divider chain
// A row of restoring cells, one quotient bit each, one transaction per cycle.
// ----------------------------------------------------------------------------
module mts_div_chain (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mts_pkg::t_div i_d,
    output mts_pkg::t_div      o_d
);

    mts_pkg::t_div stage [mts_pkg::NSTEP+1];

    assign stage[0] = i_d;

    for (genvar g = 0; g < mts_pkg::NSTEP; g++) begin : g_cell
        mts_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (stage[g]),
            .o_d     (stage[g+1])
        );
    end

    assign o_d = stage[mts_pkg::NSTEP];

endmodule
`default_nettype wire

@@ rtl/midtone_transfer_stretch.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Midtones transfer stretch
// Forward or inverse MTF stretch of one channel, one sample per clock.
// ----------------------------------------------------------------------------
//  channel    handshake                  payload
//  sample in  start (busy is always low)  i_pixel_in
//  result     o_valid strobe             o_pixel_out
//  config     i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One sample is taken every cycle; each result passes through the two chains of
// restoring divider cells and the eight registers around them.
// Reset is synchronous and clears the pipeline valid bits and the configuration registers.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module midtone_transfer_stretch (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire mts_pkg::t_val i_pixel_in,
    output logic             o_valid,
    output mts_pkg::t_val    o_pixel_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire mts_pkg::t_val i_cfg_data
);

    localparam int VW = mts_pkg::VW;
    localparam int DW = mts_pkg::DW;
    localparam int F  = mts_pkg::FRAC_BITS;

    mts_pkg::t_val r_shadow, r_highlight, r_midtone;
    logic          r_inverse;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow    <= '0;
            r_highlight <= mts_pkg::ONE_V;
            r_midtone   <= mts_pkg::HALF_V;
            r_inverse   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (mts_pkg::t_reg_idx'(i_cfg_index))
                mts_pkg::REG_SHADOW:    r_shadow    <= i_cfg_data;
                mts_pkg::REG_HIGHLIGHT: r_highlight <= i_cfg_data;
                mts_pkg::REG_MIDTONE:   r_midtone   <= i_cfg_data;
                mts_pkg::REG_MODE:      r_inverse   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Signed span and extended register values used by the stages below.
    logic signed [VW:0] span, s_s, m_s;
    assign s_s  = $signed({1'b0, r_shadow});
    assign m_s  = $signed({1'b0, r_midtone});
    assign span = $signed({1'b0, r_highlight}) - s_s;

    // Stage 0: input register.
    logic          r0_valid;
    mts_pkg::t_val r0_pix;

    always_ff @(posedge i_clk) begin
        r0_pix <= i_pixel_in;
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start & ~busy;
        end
    end

    // Stage 1: normalising quotient set-up.
    logic signed [VW:0] num1, span_f;
    mts_pkg::t_div      n1, r1, a_out;

    always_comb begin
        num1   = $signed({1'b0, r0_pix}) - s_s;
        span_f = (span < $signed((VW+1)'(1))) ? $signed((VW+1)'(1)) : span;
        n1              = '0;
        n1.tag.valid    = r0_valid;
        n1.tag.inv      = r_inverse;
        n1.tag.pix      = r0_pix;
        n1.b            = DW'(span_f[VW-1:0]);
        if (num1 <= $signed((VW+1)'(0))) begin
            n1.tag.force_en = 1'b1;
            n1.tag.fval     = '0;
        end else if (num1 >= span_f) begin
            n1.tag.force_en = 1'b1;
            n1.tag.fval     = mts_pkg::ONE_V;
        end else begin
            n1.r = DW'(num1[VW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r1 <= n1;
        if (!i_rst_n) begin
            r1.tag.valid <= 1'b0;
        end
    end

    mts_div_chain u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r1),
        .o_d     (a_out)
    );

    // Stage 2: MTF argument.
    logic          r2_valid, r2_inv;
    mts_pkg::t_val r2_x;

    always_ff @(posedge i_clk) begin
        r2_inv <= a_out.tag.inv;
        r2_x   <= a_out.tag.inv ? a_out.tag.pix : mts_pkg::div_round(a_out);
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= a_out.tag.valid;
        end
    end

    // Stage 3: numerator and denominator products.
    logic signed [VW+1:0] coef1, coef2;
    logic signed [VW:0]   xs;
    logic signed [DW:0]   p1_full, p2_full;
    logic signed [DW-1:0] r3_p1, r3_p2;
    logic                 r3_valid, r3_inv, r3_force;
    mts_pkg::t_val        r3_fval;

    always_comb begin
        xs      = $signed({1'b0, r2_x});
        coef1   = r2_inv ? (VW+2)'(m_s) : (VW+2)'(m_s) - $signed((VW+2)'(mts_pkg::ONE_V));
        coef2   = ((VW+2)'(m_s) <<< 1) - $signed((VW+2)'(mts_pkg::ONE_V));
        p1_full = coef1 * xs;
        p2_full = coef2 * xs;
    end

    always_ff @(posedge i_clk) begin
        r3_p1    <= p1_full[DW-1:0];
        r3_p2    <= p2_full[DW-1:0];
        r3_inv   <= r2_inv;
        r3_force <= (r2_x == '0) || (r2_x >= mts_pkg::ONE_V);
        r3_fval  <= (r2_x == '0) ? '0 : mts_pkg::ONE_V;
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    // Stage 4: complete the denominator.
    logic signed [DW-1:0] m_one, one_sq;
    logic signed [DW-1:0] r4_num, r4_den;
    logic                 r4_valid, r4_inv, r4_force;
    mts_pkg::t_val        r4_fval;

    assign m_one  = $signed(DW'(r_midtone)) <<< F;
    assign one_sq = $signed(DW'(1)) <<< (2 * F);

    always_ff @(posedge i_clk) begin
        r4_num   <= r3_p1;
        r4_den   <= r3_p2 - m_one + (r3_inv ? one_sq : '0);
        r4_inv   <= r3_inv;
        r4_force <= r3_force;
        r4_fval  <= r3_fval;
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    // Stage 5: sign and end handling of the MTF quotient.
    logic [DW-1:0] a_mag, b_mag;
    mts_pkg::t_div n5, r5, b_out;

    always_comb begin
        a_mag = r4_num[DW-1] ? DW'(-r4_num) : DW'(r4_num);
        b_mag = r4_den[DW-1] ? DW'(-r4_den) : DW'(r4_den);
        n5              = '0;
        n5.tag.valid    = r4_valid;
        n5.tag.inv      = r4_inv;
        n5.b            = b_mag;
        priority if (r4_force) begin
            n5.tag.force_en = 1'b1;
            n5.tag.fval     = r4_fval;
        end else if (r4_den == '0) begin
            n5.tag.force_en = 1'b1;
            n5.tag.fval     = r4_inv ? '0 : mts_pkg::HALF_V;
        end else if ((r4_num == '0) || (r4_num[DW-1] != r4_den[DW-1])) begin
            n5.tag.force_en = 1'b1;
            n5.tag.fval     = '0;
        end else if (a_mag >= b_mag) begin
            n5.tag.force_en = 1'b1;
            n5.tag.fval     = mts_pkg::ONE_V;
        end else begin
            n5.r = a_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r5 <= n5;
        if (!i_rst_n) begin
            r5.tag.valid <= 1'b0;
        end
    end

    mts_div_chain u_mtf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r5),
        .o_d     (b_out)
    );

    // Stage 6: inverse rescale product.
    mts_pkg::t_val        vn;
    logic signed [DW-1:0] prod;
    logic signed [DW-1:0] r6_prod;
    logic                 r6_valid, r6_inv;
    mts_pkg::t_val        r6_vn;

    assign vn   = mts_pkg::div_round(b_out);
    assign prod = $signed({1'b0, vn}) * span;

    always_ff @(posedge i_clk) begin
        r6_prod <= prod;
        r6_vn   <= vn;
        r6_inv  <= b_out.tag.inv;
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= b_out.tag.valid;
        end
    end

    // Stage 7: in inverse mode round to nearest, add the shadow level and clamp; in forward mode pass the quotient on.
    logic signed [DW:0] t_rnd, scaled, total;

    always_comb begin
        t_rnd  = (DW+1)'(r6_prod) + $signed((DW+1)'(mts_pkg::HALF_V));
        scaled = t_rnd >>> F;
        total  = scaled + (DW+1)'(s_s);
    end

    always_ff @(posedge i_clk) begin
        if (!r6_inv) begin
            o_pixel_out <= r6_vn;
        end else if (total < $signed((DW+1)'(0))) begin
            o_pixel_out <= '0;
        end else if (total > $signed((DW+1)'(mts_pkg::ONE_V))) begin
            o_pixel_out <= mts_pkg::ONE_V;
        end else begin
            o_pixel_out <= total[VW-1:0];
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r6_valid;
        end
    end

endmodule
`default_nettype wire

@@ bench/tb_midtone_transfer_stretch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midtones transfer stretch testbench
// Drives directed and random samples through several register settings and
// compares every result strobe with a fixed value or a behavioural model of the stretch.
// ----------------------------------------------------------------------------
module tb_midtone_transfer_stretch;
    import mts_pkg::*;

    localparam int LATENCY = 2 * (FRAC_BITS + 1) + 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam int N_RANDOM = 1650;
    localparam logic [VW-1:0] NO_EXP = '1;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_val       i_pixel_in;
    logic       o_valid;
    t_val       o_pixel_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    t_val       i_cfg_data;

    midtone_transfer_stretch u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel_in(i_pixel_in), .o_valid(o_valid), .o_pixel_out(o_pixel_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Model copy of the registers.
    longint shadow_lvl, highlight_lvl, midtone_lvl;
    bit     invert_en;

    t_val   pending_pixels[$];
    int     error_count;
    int     idle_cycles;
    bit     timed_out;

    typedef struct {
        t_val pix;
        t_val want;   // NO_EXP when the predictor decides
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint quotient_frac(longint a, longint b);
        longint q, r;
        q = 0;
        r = a;
        if (a >= b) return ONE_L;
        for (int i = 0; i <= FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q = q | 1;
            end
        end
        return (q + 1) >>> 1;
    endfunction

    function automatic longint signed_quotient(longint num, longint den);
        if (num == 0) return 0;
        if ((num < 0) != (den < 0)) return 0;
        return quotient_frac(num < 0 ? -num : num, den < 0 ? -den : den);
    endfunction

    function automatic t_val stretch_pixel(t_val pix_in);
        longint pix, span, xn, num, den, res, vn, t, scaled;
        pix = longint'(pix_in);
        span = highlight_lvl - shadow_lvl;
        if (!invert_en) begin
            if (span < 1) span = 1;
            xn = signed_quotient(pix - shadow_lvl, span);
            if (xn <= 0) res = 0;
            else if (xn >= ONE_L) res = ONE_L;
            else begin
                num = (midtone_lvl - ONE_L) * xn;
                den = (2 * midtone_lvl - ONE_L) * xn - midtone_lvl * ONE_L;
                res = (den == 0) ? ONE_L / 2 : signed_quotient(num, den);
            end
        end else begin
            if (pix <= 0) vn = 0;
            else if (pix >= ONE_L) vn = ONE_L;
            else begin
                num = midtone_lvl * pix;
                den = (2 * midtone_lvl - ONE_L) * pix - midtone_lvl * ONE_L
                      + ONE_L * ONE_L;
                vn = (den == 0) ? 0 : signed_quotient(num, den);
            end
            t = vn * span + ONE_L / 2;
            if (t >= 0) scaled = t >>> FRAC_BITS;
            else scaled = -((-t + ONE_L - 1) >>> FRAC_BITS);
            res = scaled + shadow_lvl;
            if (res < 0) res = 0;
            if (res > ONE_L) res = ONE_L;
        end
        return t_val'(res);
    endfunction

    // Result checker and watchdog, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_val want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                if (pending_pixels.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= 10)
                        $display("unexpected result %0d", o_pixel_out);
                end else begin
                    want = pending_pixels.pop_front();
                    if (want !== o_pixel_out) begin
                        error_count = error_count + 1;
                        if (error_count <= 10)
                            $display("pixel_out mismatch: expected %0d, got %0d",
                                     want, o_pixel_out);
                    end
                end
            end
        end
    end

    // Drops start only when the gap is not empty.
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40)
                                         : $urandom_range(0, 2);
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic write_register(t_reg_idx idx, t_val value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SHADOW:    shadow_lvl    = longint'(value);
            REG_HIGHLIGHT: highlight_lvl = longint'(value);
            REG_MIDTONE:   midtone_lvl   = longint'(value);
            default:       invert_en     = value[0];
        endcase
        @(negedge i_clk);
    endtask

    // Presents one sample; a gap of zero keeps start high across transactions.
    task automatic send_sample(t_val pix, t_val want, bit gappy);
        start      <= 1'b1;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_pixels = {pending_pixels, (want == NO_EXP) ? stretch_pixel(pix) : want};
        @(negedge i_clk);
        if (gappy && $urandom_range(0, 2) == 0) begin
            random_gap();
        end
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic t_val random_value();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return ONE_V;
            2: return t_val'($urandom);            // above ONE as well
            3: return t_val'(ONE_V - $urandom_range(0, 3));
            default: return t_val'($urandom_range(0, 65536));
        endcase
    endfunction

    t_row directed[] = '{
        '{pix: 0, want: 0}, '{pix: ONE_V, want: ONE_V},
        '{pix: HALF_V, want: NO_EXP}, '{pix: 1, want: NO_EXP},
        '{pix: ONE_V - 1, want: NO_EXP}, '{pix: 17'h1FFFF, want: ONE_V},
        '{pix: 17'h15555, want: ONE_V}, '{pix: 17'h0AAAA, want: NO_EXP}
    };

    initial begin
        int phase;
        timed_out = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        start = 1'b0;
        i_pixel_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_SHADOW;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        shadow_lvl = 0;
        highlight_lvl = ONE_L;
        midtone_lvl = ONE_L / 2;
        invert_en = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, then inverse mode and awkward settings.
        foreach (directed[k]) send_sample(directed[k].pix, directed[k].want, 1'b0);
        start <= 1'b0;
        drain();
        write_register(REG_MODE, t_val'(1));
        foreach (directed[k]) send_sample(directed[k].pix, NO_EXP, 1'b0);
        start <= 1'b0;
        drain();
        // Zero span in forward, m = 0 and m = ONE, negative span in inverse.
        write_register(REG_MODE, t_val'(0));
        write_register(REG_SHADOW, HALF_V);
        write_register(REG_HIGHLIGHT, HALF_V);
        write_register(REG_MIDTONE, t_val'(0));
        send_sample(HALF_V, NO_EXP, 1'b0);
        send_sample(HALF_V + 1, NO_EXP, 1'b0);
        send_sample(HALF_V - 1, NO_EXP, 1'b0);
        start <= 1'b0;
        drain();
        write_register(REG_MIDTONE, ONE_V);
        write_register(REG_SHADOW, ONE_V);
        write_register(REG_HIGHLIGHT, t_val'(0));
        send_sample(HALF_V, NO_EXP, 1'b0);
        start <= 1'b0;
        drain();
        write_register(REG_MODE, t_val'(1));
        send_sample(HALF_V, NO_EXP, 1'b0);
        send_sample(ONE_V, NO_EXP, 1'b0);
        start <= 1'b0;
        drain();

        // Random phases, each with fresh register values.
        for (phase = 0; phase < 11; phase++) begin
            write_register(REG_SHADOW, (phase % 4 == 0) ? t_val'(0) : random_value());
            write_register(REG_HIGHLIGHT,
                           (phase % 4 == 0) ? ONE_V : t_val'($urandom_range(0, 65536)));
            write_register(REG_MIDTONE, random_value());
            write_register(REG_MODE, t_val'(phase % 2));
            for (int n = 0; n < N_RANDOM / 11; n++)
                send_sample(random_value(), NO_EXP, (phase % 3) != 1);
            start <= 1'b0;
            drain();
        end

        if (error_count == 0 && pending_pixels.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/mts_pkg.sv
rtl/mts_div_cell.sv
rtl/mts_div_chain.sv
rtl/midtone_transfer_stretch.sv
bench/tb_midtone_transfer_stretch.sv
